// ----- src/ntcat_pkg.sv -----
// Package for the NTC ADC-to-temperature block: sizes, the thermistor ROM,
// and the command/status structs shared by the controller and the datapath.
// No dependencies.
package ntcat_pkg;

  localparam int ADC_BITS            = 12;
  localparam int TABLE_ENTRIES       = 140;
  localparam int FIRST_DEGREE_OFFSET = 20;
  localparam int TEMP_W              = 12;
  localparam int DEG_TENTHS          = 10;

  localparam int IDX_W    = $clog2(TABLE_ENTRIES);
  localparam int LAST_IDX = TABLE_ENTRIES - 1;
  // (code - low) * 10 fits in four more bits than the code.
  localparam int NUM_W    = ADC_BITS + 4;
  localparam int CNT_W    = $clog2(NUM_W);
  localparam int CALC_W   = NUM_W + 8;

  // Thermistor divider codes, one per whole degree, hottest entry last.
  function automatic logic [ADC_BITS-1:0] ntc_rom(input logic [IDX_W-1:0] idx);
    logic [15:0] v;
    case (idx)
      8'd0: v = 16'd3568;   8'd1: v = 16'd3546;   8'd2: v = 16'd3523;   8'd3: v = 16'd3499;
      8'd4: v = 16'd3475;   8'd5: v = 16'd3449;   8'd6: v = 16'd3424;   8'd7: v = 16'd3397;
      8'd8: v = 16'd3370;   8'd9: v = 16'd3342;   8'd10: v = 16'd3314;  8'd11: v = 16'd3285;
      8'd12: v = 16'd3255;  8'd13: v = 16'd3225;  8'd14: v = 16'd3194;  8'd15: v = 16'd3162;
      8'd16: v = 16'd3130;  8'd17: v = 16'd3098;  8'd18: v = 16'd3064;  8'd19: v = 16'd3031;
      8'd20: v = 16'd2996;  8'd21: v = 16'd2962;  8'd22: v = 16'd2927;  8'd23: v = 16'd2891;
      8'd24: v = 16'd2855;  8'd25: v = 16'd2818;  8'd26: v = 16'd2781;  8'd27: v = 16'd2744;
      8'd28: v = 16'd2706;  8'd29: v = 16'd2669;  8'd30: v = 16'd2630;  8'd31: v = 16'd2592;
      8'd32: v = 16'd2553;  8'd33: v = 16'd2515;  8'd34: v = 16'd2476;  8'd35: v = 16'd2437;
      8'd36: v = 16'd2398;  8'd37: v = 16'd2359;  8'd38: v = 16'd2319;  8'd39: v = 16'd2280;
      8'd40: v = 16'd2241;  8'd41: v = 16'd2202;  8'd42: v = 16'd2163;  8'd43: v = 16'd2125;
      8'd44: v = 16'd2086;  8'd45: v = 16'd2048;  8'd46: v = 16'd2009;  8'd47: v = 16'd1971;
      8'd48: v = 16'd1933;  8'd49: v = 16'd1896;  8'd50: v = 16'd1859;  8'd51: v = 16'd1822;
      8'd52: v = 16'd1785;  8'd53: v = 16'd1749;  8'd54: v = 16'd1714;  8'd55: v = 16'd1678;
      8'd56: v = 16'd1643;  8'd57: v = 16'd1607;  8'd58: v = 16'd1575;  8'd59: v = 16'd1541;
      8'd60: v = 16'd1508;  8'd61: v = 16'd1475;  8'd62: v = 16'd1443;  8'd63: v = 16'd1411;
      8'd64: v = 16'd1379;  8'd65: v = 16'd1349;  8'd66: v = 16'd1319;  8'd67: v = 16'd1289;
      8'd68: v = 16'd1259;  8'd69: v = 16'd1231;  8'd70: v = 16'd1203;  8'd71: v = 16'd1175;
      8'd72: v = 16'd1148;  8'd73: v = 16'd1122;  8'd74: v = 16'd1096;  8'd75: v = 16'd1070;
      8'd76: v = 16'd1045;  8'd77: v = 16'd1021;  8'd78: v = 16'd997;   8'd79: v = 16'd973;
      8'd80: v = 16'd950;   8'd81: v = 16'd927;   8'd82: v = 16'd905;   8'd83: v = 16'd883;
      8'd84: v = 16'd862;   8'd85: v = 16'd842;   8'd86: v = 16'd822;   8'd87: v = 16'd802;
      8'd88: v = 16'd783;   8'd89: v = 16'd764;   8'd90: v = 16'd746;   8'd91: v = 16'd728;
      8'd92: v = 16'd710;   8'd93: v = 16'd693;   8'd94: v = 16'd677;   8'd95: v = 16'd661;
      8'd96: v = 16'd645;   8'd97: v = 16'd629;   8'd98: v = 16'd614;   8'd99: v = 16'd599;
      8'd100: v = 16'd585;  8'd101: v = 16'd571;  8'd102: v = 16'd558;  8'd103: v = 16'd544;
      8'd104: v = 16'd531;  8'd105: v = 16'd518;  8'd106: v = 16'd506;  8'd107: v = 16'd495;
      8'd108: v = 16'd483;  8'd109: v = 16'd471;  8'd110: v = 16'd460;  8'd111: v = 16'd449;
      8'd112: v = 16'd439;  8'd113: v = 16'd428;  8'd114: v = 16'd418;  8'd115: v = 16'd409;
      8'd116: v = 16'd399;  8'd117: v = 16'd389;  8'd118: v = 16'd381;  8'd119: v = 16'd372;
      8'd120: v = 16'd363;  8'd121: v = 16'd354;  8'd122: v = 16'd346;  8'd123: v = 16'd339;
      8'd124: v = 16'd331;  8'd125: v = 16'd323;  8'd126: v = 16'd316;  8'd127: v = 16'd308;
      8'd128: v = 16'd301;  8'd129: v = 16'd295;  8'd130: v = 16'd288;  8'd131: v = 16'd282;
      8'd132: v = 16'd275;  8'd133: v = 16'd269;  8'd134: v = 16'd263;  8'd135: v = 16'd257;
      8'd136: v = 16'd251;  8'd137: v = 16'd246;  8'd138: v = 16'd241;  8'd139: v = 16'd236;
      default: v = 16'd0;
    endcase
    return v[ADC_BITS-1:0];
  endfunction

  localparam logic [ADC_BITS-1:0] ROM_HEAD = ntc_rom(IDX_W'(0));
  localparam logic [ADC_BITS-1:0] ROM_TAIL = ntc_rom(IDX_W'(LAST_IDX));

  typedef struct packed {
    logic load;
    logic scan;
    logic div_step;
    logic finish;
  } ntcat_cmd_t;

  typedef struct packed {
    logic scan_stop;
    logic div_last;
  } ntcat_sts_t;

endpackage

// ----- src/ntcat_ctrl.sv -----
// Controller state machine for the NTC ADC-to-temperature block.
// Depends on ntcat_pkg for the command and status structs.
module ntcat_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  ntcat_pkg::ntcat_sts_t  sts,
  output ntcat_pkg::ntcat_cmd_t  cmd,
  output logic                   busy
);
  import ntcat_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } ntcat_state_t;

  ntcat_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_stop) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/ntcat_dpath.sv -----
// Datapath for the NTC ADC-to-temperature block: clamp, ROM scan,
// restoring divider for the interpolation, and the output register.
// Depends on ntcat_pkg for sizes, the ROM and the command/status structs.
module ntcat_dpath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ntcat_pkg::ntcat_cmd_t                 cmd,
  output ntcat_pkg::ntcat_sts_t                 sts,
  input  logic [ntcat_pkg::ADC_BITS-1:0]        adc_code,
  output logic                                  out_valid,
  output logic signed [ntcat_pkg::TEMP_W-1:0]   temperature_tenths
);
  import ntcat_pkg::*;

  logic [ADC_BITS-1:0] code_r, code_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [ADC_BITS-1:0] hi_r, hi_nxt;
  logic [ADC_BITS-1:0] step_r, step_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [ADC_BITS-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                frac_en_r, frac_en_nxt;
  logic                out_valid_r;
  logic [TEMP_W-1:0]   temp_r, temp_nxt;

  logic [ADC_BITS-1:0] rom_q;
  logic                scan_more;
  logic [ADC_BITS-1:0] diff;
  logic [NUM_W-1:0]    num_init;
  logic [ADC_BITS-1:0] step_v;
  logic [ADC_BITS:0]   rem_sh;
  logic [ADC_BITS:0]   rem_sub;
  logic                ge;
  logic                round_up;
  logic [CALC_W-1:0]   frac;
  logic [CALC_W-1:0]   temp_calc;

  assign rom_q     = ntc_rom(pos_r);
  assign scan_more = (pos_r != IDX_W'(LAST_IDX)) && (code_r < rom_q);
  assign diff      = code_r - rom_q;
  assign num_init  = NUM_W'({diff, 3'b000}) + NUM_W'({diff, 1'b0});
  assign step_v    = (hi_r > rom_q) ? (hi_r - rom_q) : '0;

  assign rem_sh    = {rem_r, num_r[NUM_W-1]};
  assign rem_sub   = rem_sh - {1'b0, step_r};
  assign ge        = (rem_sh >= {1'b0, step_r});

  // Round the fraction up when the remainder is above half the step.
  assign round_up  = (rem_r > (step_r >> 1));
  assign frac      = frac_en_r ? (CALC_W'(num_r) + CALC_W'(round_up)) : '0;
  assign temp_calc = CALC_W'(pos_r) * CALC_W'(DEG_TENTHS)
                   - CALC_W'(FIRST_DEGREE_OFFSET * DEG_TENTHS) - frac;

  assign sts.scan_stop = !scan_more;
  assign sts.div_last  = (cnt_r == CNT_W'(NUM_W - 1));

  always_comb begin
    code_nxt    = code_r;
    pos_nxt     = pos_r;
    hi_nxt      = hi_r;
    step_nxt    = step_r;
    num_nxt     = num_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    frac_en_nxt = frac_en_r;
    temp_nxt    = temp_r;

    if (cmd.load) begin
      if (adc_code > ROM_HEAD) begin
        code_nxt = ROM_HEAD;
      end else if (adc_code < ROM_TAIL) begin
        code_nxt = ROM_TAIL;
      end else begin
        code_nxt = adc_code;
      end
      pos_nxt = '0;
      hi_nxt  = '0;
    end

    if (cmd.scan) begin
      if (scan_more) begin
        hi_nxt  = rom_q;
        pos_nxt = pos_r + 1'b1;
      end else begin
        step_nxt    = step_v;
        num_nxt     = num_init;
        rem_nxt     = '0;
        cnt_nxt     = '0;
        frac_en_nxt = (pos_r != '0) && (step_v != '0) && (code_r >= rom_q);
      end
    end

    if (cmd.div_step) begin
      rem_nxt = ge ? rem_sub[ADC_BITS-1:0] : rem_sh[ADC_BITS-1:0];
      num_nxt = {num_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
    end

    if (cmd.finish) begin
      temp_nxt = temp_calc[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    code_r    <= code_nxt;
    pos_r     <= pos_nxt;
    hi_r      <= hi_nxt;
    step_r    <= step_nxt;
    num_r     <= num_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    frac_en_r <= frac_en_nxt;
    temp_r    <= temp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  assign out_valid          = out_valid_r;
  assign temperature_tenths = $signed(temp_r);

endmodule

// ----- src/ntc_adc_to_temperature_core.sv -----
// Top level of the NTC ADC-to-temperature block.
// Depends on ntcat_pkg, ntcat_ctrl and ntcat_dpath.
//
//   Channel   Ports                              Handshake
//   --------  ---------------------------------  ------------------------------
//   input     in_adc_code                        taken when start && !busy
//   result    out_temperature_tenths             one cycle, marked by out_valid
//
// An item runs through a ROM scan (one table entry per cycle, up to pos,
// the index of the first entry not above the clamped code), then a restoring
// divide for the interpolation between pos - 1 and pos, and a last state to
// form the result. busy drops in the cycle that shows the result, so a new
// item may be taken then.
// Reset is synchronous and active low; it clears the controller and the
// result strobe. The receiver cannot stall: each result is shown once.
module ntc_adc_to_temperature_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ntcat_pkg::ADC_BITS-1:0]       in_adc_code,
  output logic                                 out_valid,
  output logic signed [ntcat_pkg::TEMP_W-1:0]  out_temperature_tenths
);
  import ntcat_pkg::*;

  // Commands from the controller and status back from the datapath.
  ntcat_cmd_t cmd;
  ntcat_sts_t sts;

  // The controller steps through idle, scan, divide and done.
  ntcat_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the clamped code, the scan index and the divider.
  ntcat_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .adc_code           (in_adc_code),
    .out_valid          (out_valid),
    .temperature_tenths (out_temperature_tenths)
  );

endmodule

// ----- src/ntcat_chk.sv -----
// Port-level checker for the NTC ADC-to-temperature block, bound to the top.
// Depends on ntcat_pkg for the result width.
module ntcat_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 out_valid,
  input logic signed [ntcat_pkg::TEMP_W-1:0]  out_temperature_tenths
);
  import ntcat_pkg::*;

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after an item was taken");

  // A result strobe lasts one cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // The result is shown as the block goes idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Finishing an item always delivers its result.
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("item finished without a result");

  // Temperatures stay within the table span.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_tenths >= -12'sd200 &&
                   out_temperature_tenths <= 12'sd1190))
    else $error("temperature outside the table span");

endmodule

bind ntc_adc_to_temperature_core ntcat_chk u_ntcat_chk (.*);
